@@ rtl/core/chi_pkg.sv @@
package chi_pkg;

   localparam int HASH_SIZE  = 1024;
   localparam int INDEX_SIZE = 4096;
   localparam int HASH_BITS  = $clog2(HASH_SIZE);
   localparam int INDEX_BITS = $clog2(INDEX_SIZE);
   // one extra bit so the end marker never collides with an index
   localparam int LINK_BITS  = INDEX_BITS + 1;

   localparam logic [LINK_BITS-1:0] LINK_END = '1;

   localparam logic [2:0] CMD_ADD    = 3'd0;
   localparam logic [2:0] CMD_REMOVE = 3'd1;
   localparam logic [2:0] CMD_FIRST  = 3'd2;
   localparam logic [2:0] CMD_NEXT   = 3'd3;
   localparam logic [2:0] CMD_CLEAR  = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_LOOP  = 2'd2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] key;
      logic [15:0] index;
   } chi_req_type;

   typedef struct packed {
      logic [11:0] result_index;
      logic        result_valid;
      logic [1:0]  status;
   } chi_rsp_type;

endpackage

@@ rtl/core/chained_index_hash_table.sv @@
// channel | dir | handshake            | beat
// req_    | in  | req_valid/req_stall  | chi_req_type: cmd, key, index
// rsp_    | out | rsp_valid/rsp_stall  | chi_rsp_type: result_index, result_valid, status
//
// add, first, next, unknown and out-of-range commands: memories read on accept, result formed in the exec state
// remove: also walks the chain one node per step through the link memory read port, up to 4096 nodes
// clear: sweeps all bucket heads, one bucket head written per cycle
// after reset a sweep empties the bucket heads; req_stall is high meanwhile
// a finished result is parked while rsp_stall holds the output register; req_stall stays high
module chained_index_hash_table
   import chi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  chi_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output chi_rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_HOLD
   } state_type;

   localparam logic [HASH_BITS-1:0] SWEEP_LAST = HASH_BITS'(HASH_SIZE - 1);

   // storage: bucket heads and per-index successor links
   logic [LINK_BITS-1:0] head_mem [HASH_SIZE];
   logic [LINK_BITS-1:0] link_mem [INDEX_SIZE];
   logic [LINK_BITS-1:0] head_rd_ff;
   logic [LINK_BITS-1:0] link_rd_ff;

   // sequencer state
   state_type             state_ff, state_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;
   logic                  inrng_ff, inrng_in;
   logic [HASH_BITS-1:0]  bkt_ff, bkt_in;
   logic [LINK_BITS-1:0]  cur_ff, cur_in;
   logic [INDEX_BITS-1:0] step_ff, step_in;
   logic [LINK_BITS-1:0]  lidx_ff, lidx_in;
   logic [HASH_BITS-1:0]  sweep_ff, sweep_in;
   logic                  sweep_rsp_ff, sweep_rsp_in;
   chi_rsp_type           pend_ff, pend_in;
   chi_rsp_type           rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // memory port controls
   logic                  head_we;
   logic [HASH_BITS-1:0]  head_wa;
   logic [LINK_BITS-1:0]  head_wd;
   logic [HASH_BITS-1:0]  head_ra;
   logic                  link_we;
   logic [INDEX_BITS-1:0] link_wa;
   logic [LINK_BITS-1:0]  link_wd;
   logic [INDEX_BITS-1:0] link_ra;

   logic                  req_acc;
   logic                  out_free;
   logic                  fin;
   chi_rsp_type           fin_res;
   logic [LINK_BITS-1:0]  idx_link;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   // output register is empty or being drained this edge
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign idx_link  = {1'b0, idx_ff};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      inrng_in     = inrng_ff;
      bkt_in       = bkt_ff;
      cur_in       = cur_ff;
      step_in      = step_ff;
      lidx_in      = lidx_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      head_we = 1'b0;
      head_wa = bkt_ff;
      head_wd = LINK_END;
      head_ra = req_data.key[HASH_BITS-1:0];
      link_we = 1'b0;
      link_wa = idx_ff;
      link_wd = LINK_END;
      link_ra = req_data.index[INDEX_BITS-1:0];

      fin     = 1'b0;
      fin_res = '0;

      case (state_ff)
         S_SWEEP: begin
            // one bucket head per cycle back to the end marker
            head_we  = 1'b1;
            head_wa  = sweep_ff;
            head_wd  = LINK_END;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == SWEEP_LAST) begin
               if (sweep_rsp_ff) begin
                  fin            = 1'b1;
                  fin_res.status = ST_OK;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         S_IDLE: begin
            if (req_acc) begin
               cmd_in   = req_data.cmd;
               idx_in   = req_data.index[INDEX_BITS-1:0];
               inrng_in = (req_data.index[15:INDEX_BITS] == '0);
               bkt_in   = req_data.key[HASH_BITS-1:0];
               if (req_data.cmd == CMD_CLEAR) begin
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = S_SWEEP;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end

         S_EXEC: begin
            // head_rd_ff = bucket head, link_rd_ff = link of index
            case (cmd_ff)
               CMD_ADD: begin
                  fin = 1'b1;
                  if (!inrng_ff) begin
                     fin_res.status = ST_RANGE;
                  end else begin
                     link_we = 1'b1;
                     link_wa = idx_ff;
                     link_wd = head_rd_ff;
                     head_we = 1'b1;
                     head_wa = bkt_ff;
                     head_wd = idx_link;
                  end
               end

               CMD_REMOVE: begin
                  if (!inrng_ff) begin
                     fin            = 1'b1;
                     fin_res.status = ST_RANGE;
                  end else if (head_rd_ff == idx_link) begin
                     fin = 1'b1;
                     if (link_rd_ff == idx_link) begin
                        fin_res.status = ST_LOOP;
                     end else begin
                        head_we = 1'b1;
                        head_wa = bkt_ff;
                        head_wd = link_rd_ff;
                     end
                  end else if (head_rd_ff == LINK_END) begin
                     fin = 1'b1;
                  end else begin
                     // start walking from the head
                     link_ra  = head_rd_ff[INDEX_BITS-1:0];
                     cur_in   = head_rd_ff;
                     step_in  = '0;
                     lidx_in  = link_rd_ff;
                     state_in = S_WALK;
                  end
               end

               CMD_FIRST: begin
                  fin = 1'b1;
                  if (head_rd_ff != LINK_END) begin
                     fin_res.result_index = head_rd_ff[INDEX_BITS-1:0];
                     fin_res.result_valid = 1'b1;
                  end
               end

               CMD_NEXT: begin
                  fin = 1'b1;
                  if (!inrng_ff) begin
                     fin_res.status = ST_RANGE;
                  end else if (link_rd_ff == idx_link) begin
                     fin_res.status = ST_LOOP;
                  end else if (link_rd_ff != LINK_END) begin
                     fin_res.result_index = link_rd_ff[INDEX_BITS-1:0];
                     fin_res.result_valid = 1'b1;
                  end
               end

               default: begin
                  fin = 1'b1;
               end
            endcase
         end

         S_WALK: begin
            // link_rd_ff holds the successor of cur_ff
            if (link_rd_ff == cur_ff) begin
               fin            = 1'b1;
               fin_res.status = ST_LOOP;
            end else if (link_rd_ff == idx_link) begin
               fin = 1'b1;
               if (lidx_ff == idx_link) begin
                  fin_res.status = ST_LOOP;
               end else begin
                  // unlink: predecessor skips over the removed index
                  link_we = 1'b1;
                  link_wa = cur_ff[INDEX_BITS-1:0];
                  link_wd = lidx_ff;
               end
            end else if (link_rd_ff == LINK_END) begin
               fin = 1'b1;
            end else if (step_ff == '1) begin
               // chain longer than the index space
               fin            = 1'b1;
               fin_res.status = ST_LOOP;
            end else begin
               link_ra = link_rd_ff[INDEX_BITS-1:0];
               cur_in  = link_rd_ff;
               step_in = step_ff + 1'b1;
            end
         end

         S_HOLD: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (fin) begin
         sweep_rsp_in = 1'b0;
         if (out_free) begin
            rsp_in       = fin_res;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end else begin
            pend_in  = fin_res;
            state_in = S_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      inrng_ff <= inrng_in;
      bkt_ff   <= bkt_in;
      cur_ff   <= cur_in;
      step_ff  <= step_in;
      lidx_ff  <= lidx_in;
      pend_ff  <= pend_in;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_wa] <= head_wd;
      end
      head_rd_ff <= head_mem[head_ra];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[link_ra];
   end

endmodule
